/* rtl/core/gci_pkg.sv */
// Types and constants shared by the gilbert curve index-to-xy core.
// No dependencies.
package gci_pkg;
   localparam int unsigned IDX_W = 24;
   localparam int unsigned REG_W = 13;
   localparam int unsigned CRD_W = 12;
   localparam int unsigned VW    = 16;
   localparam int unsigned SUM_W = 26;
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic signed [VW-1:0]   ax;
      logic signed [VW-1:0]   ay;
      logic signed [VW-1:0]   bx;
      logic signed [VW-1:0]   by;
      logic signed [VW-1:0]   x;
      logic signed [VW-1:0]   y;
      logic        [SUM_W-1:0] rem;
      logic                   done;
      logic                   oor;
   } walk_type;
endpackage

/* rtl/core/gci_cell.sv */
// One level of the curve descent, registered.
// Depends on gci_pkg.
module gci_cell (
   input  logic              clock,
   input  logic              enable,
   input  gci_pkg::walk_type walk_in,
   output gci_pkg::walk_type walk_out
);
   import gci_pkg::*;

   walk_type nx_in, nx_ff;

   function automatic logic signed [VW-1:0] sg(input logic signed [VW-1:0] v);
      sg = (v > 0) ? VW'(1) : ((v == 0) ? VW'(0) : -VW'(1));
   endfunction

   function automatic logic signed [VW-1:0] ab(input logic signed [VW-1:0] v);
      ab = v[VW-1] ? -v : v;
   endfunction

   always_comb begin
      logic signed [VW-1:0] maj, mnr, dax, day, dbx, dby, ax2, ay2, bx2, by2;
      logic signed [VW-1:0] m2, n2;
      logic signed [2*VW-1:0] p;
      logic [SUM_W-1:0] part, part2;
      logic signed [VW-1:0] di;
      nx_in = walk_in;
      maj = ab(walk_in.ax + walk_in.ay);
      mnr = ab(walk_in.bx + walk_in.by);
      dax = sg(walk_in.ax); day = sg(walk_in.ay);
      dbx = sg(walk_in.bx); dby = sg(walk_in.by);
      di  = VW'(walk_in.rem);
      ax2 = walk_in.ax >>> 1; ay2 = walk_in.ay >>> 1;
      bx2 = walk_in.bx >>> 1; by2 = walk_in.by >>> 1;
      m2  = ab(ax2 + ay2);
      n2  = ab(bx2 + by2);
      part = '0; part2 = '0; p = '0;
      if (walk_in.done) begin
      end else if (mnr == VW'(1)) begin
         nx_in.x = walk_in.x + dax * di;
         nx_in.y = walk_in.y + day * di;
         nx_in.done = 1'b1;
      end else if (maj == VW'(1)) begin
         nx_in.x = walk_in.x + dbx * di;
         nx_in.y = walk_in.y + dby * di;
         nx_in.done = 1'b1;
      end else if ((maj <<< 1) > (mnr + (mnr <<< 1))) begin
         if (m2[0] && maj > VW'(2)) begin
            ax2 = ax2 + dax; ay2 = ay2 + day;
         end
         p = (ax2 + ay2) * (walk_in.bx + walk_in.by);
         part = SUM_W'(p[2*VW-1] ? -p : p);
         if (walk_in.rem < part) begin
            nx_in.ax = ax2; nx_in.ay = ay2;
         end else begin
            nx_in.rem = walk_in.rem - part;
            nx_in.x = walk_in.x + ax2; nx_in.y = walk_in.y + ay2;
            nx_in.ax = walk_in.ax - ax2; nx_in.ay = walk_in.ay - ay2;
         end
      end else begin
         if (n2[0] && mnr > VW'(2)) begin
            bx2 = bx2 + dbx; by2 = by2 + dby;
         end
         p = (bx2 + by2) * (ax2 + ay2);
         part = SUM_W'(p[2*VW-1] ? -p : p);
         p = (walk_in.ax + walk_in.ay) * ((walk_in.bx - bx2) + (walk_in.by - by2));
         part2 = SUM_W'(p[2*VW-1] ? -p : p);
         if (walk_in.rem < part) begin
            nx_in.ax = bx2; nx_in.ay = by2; nx_in.bx = ax2; nx_in.by = ay2;
         end else if (walk_in.rem - part < part2) begin
            nx_in.rem = walk_in.rem - part;
            nx_in.x = walk_in.x + bx2; nx_in.y = walk_in.y + by2;
            nx_in.bx = walk_in.bx - bx2; nx_in.by = walk_in.by - by2;
         end else begin
            nx_in.rem = walk_in.rem - part - part2;
            nx_in.x = walk_in.x + (walk_in.ax - dax) + (bx2 - dbx);
            nx_in.y = walk_in.y + (walk_in.ay - day) + (by2 - dby);
            nx_in.ax = -bx2; nx_in.ay = -by2;
            nx_in.bx = -(walk_in.ax - ax2); nx_in.by = -(walk_in.ay - ay2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nx_ff <= nx_in;
      end
   end

   assign walk_out = nx_ff;
endmodule

/* rtl/core/gilbert_curve_index_to_xy.sv */
// Top level of the gilbert curve index-to-xy core: CSRs, control, cell chain.
// Depends on gci_pkg and gci_cell.
//
// channel | ports                              | direction
// req     | req_valid req_stall req_curve_index| in
// rsp     | rsp_valid rsp_stall rsp_x_coord ...| out
// csr     | csr_write csr_index csr_data       | in
//
// One item at a time walks the row of CELLS cells, one level per cycle;
// the result is flagged valid once the control counter reaches CELLS.
// req_stall is held high from the accept until the result is taken.
// Synchronous reset clears control and sets both sides to 1.
// A stalled result holds; the next item is taken once the result is taken.
module gilbert_curve_index_to_xy #(
   parameter int unsigned CELLS = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gci_pkg::IDX_W-1:0]     req_curve_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gci_pkg::CRD_W-1:0]     rsp_x_coord,
   output logic [gci_pkg::CRD_W-1:0]     rsp_y_coord,
   output logic                          rsp_out_of_range,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [gci_pkg::REG_W-1:0]     csr_data
);
   import gci_pkg::*;

   localparam int unsigned CW = $clog2(CELLS + 2);

   logic [REG_W-1:0] width_ff, height_ff;
   logic             busy_ff;
   logic [CW-1:0]    cnt_ff;
   logic             enable;
   walk_type         head_ff, head_in;
   walk_type         chain [CELLS+1];
   logic [12:0]      w, h;
   logic [25:0]      area;

   assign w = (width_ff > 13'd4096) ? 13'd4096 : width_ff;
   assign h = (height_ff > 13'd4096) ? 13'd4096 : height_ff;
   assign area = 26'(w) * 26'(h);

   always_comb begin
      head_in = '0;
      head_in.rem = SUM_W'(req_curve_index);
      if (26'(req_curve_index) >= area) begin
         head_in.done = 1'b1;
         head_in.oor  = 1'b1;
      end else if (w >= h) begin
         head_in.ax = VW'(w); head_in.by = VW'(h);
      end else begin
         head_in.ay = VW'(h); head_in.bx = VW'(w);
      end
   end

   assign req_stall = busy_ff;
   assign enable    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= REG_W'(1);
         height_ff <= REG_W'(1);
         busy_ff   <= 1'b0;
         cnt_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_WIDTH) begin
            width_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_HEIGHT) begin
            height_ff <= csr_data;
         end
         if (!busy_ff && req_valid) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff && !rsp_valid) begin
            if (cnt_ff == CW'(CELLS)) begin
               rsp_valid <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + CW'(1);
            end
         end else if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
            busy_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff && req_valid) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      gci_cell u_cell (
         .clock   (clock),
         .enable  (enable),
         .walk_in (chain[g]),
         .walk_out(chain[g+1])
      );
   end

   assign rsp_x_coord      = chain[CELLS].oor ? '0 : CRD_W'(chain[CELLS].x);
   assign rsp_y_coord      = chain[CELLS].oor ? '0 : CRD_W'(chain[CELLS].y);
   assign rsp_out_of_range = chain[CELLS].oor;

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff) else $error("result without item");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   a_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> cnt_ff == CW'(CELLS)) else $error("early result");
endmodule

/* test/tb_gilbert_curve_index_to_xy.sv */
// Testbench for gilbert_curve_index_to_xy: directed and random curve indexes over several
// rectangle sizes, each result checked against a behavioral gilbert-curve walk.
// Depends on gci_pkg and the gilbert_curve_index_to_xy RTL.
module tb_gilbert_curve_index_to_xy;
   timeunit 1ns;
   timeprecision 1ps;
   import gci_pkg::*;

   typedef struct {
      logic [CRD_W-1:0] x;
      logic [CRD_W-1:0] y;
      logic             oor;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [IDX_W-1:0] req_curve_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CRD_W-1:0] rsp_x_coord, rsp_y_coord;
   logic rsp_out_of_range;
   logic csr_write = 1'b0;
   logic csr_index = CSR_WIDTH;
   logic [REG_W-1:0] csr_data = '0;

   logic [REG_W-1:0] rect_width = 1, rect_height = 1;
   logic [IDX_W-1:0] pending_idx[$];
   result_type expected_cells[$];
   int gap_left = 0;
   int stall_left = 0;
   bit failed = 0;

   gilbert_curve_index_to_xy uut (.*);

   always #5 clock = ~clock;

   function automatic longint fhalf(longint v);
      return v >= 0 ? v / 2 : -((-v + 1) / 2);
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic longint sgn(longint v);
      return v > 0 ? 1 : (v == 0 ? 0 : -1);
   endfunction

   function automatic result_type curve_cell(logic [IDX_W-1:0] idx);
      result_type c;
      longint w, h, ax, ay, bx, by, x, y, cur, dst;
      longint maj, mnr, dax, day, dbx, dby, di, ax2, ay2, bx2, by2, maj2, mnr2, nxt;
      longint t0, t1, t2, t3;
      w = rect_width > 4096 ? 4096 : rect_width;
      h = rect_height > 4096 ? 4096 : rect_height;
      c.x = '0; c.y = '0; c.oor = 1'b0;
      if (longint'(idx) >= w * h) begin
         c.oor = 1'b1;
         return c;
      end
      x = 0; y = 0; cur = 0; dst = idx;
      if (w >= h) begin
         ax = w; ay = 0; bx = 0; by = h;
      end else begin
         ax = 0; ay = h; bx = w; by = 0;
      end
      for (int lvl = 0; lvl < 1024; lvl++) begin
         maj = mag(ax + ay); mnr = mag(bx + by);
         dax = sgn(ax); day = sgn(ay); dbx = sgn(bx); dby = sgn(by);
         di = dst - cur;
         if (mnr == 1) begin
            x += dax * di; y += day * di; break;
         end
         if (maj == 1) begin
            x += dbx * di; y += dby * di; break;
         end
         ax2 = fhalf(ax); ay2 = fhalf(ay); bx2 = fhalf(bx); by2 = fhalf(by);
         maj2 = mag(ax2 + ay2); mnr2 = mag(bx2 + by2);
         if (2 * maj > 3 * mnr) begin
            if (maj2[0] && maj > 2) begin
               ax2 += dax; ay2 += day;
            end
            nxt = cur + mag((ax2 + ay2) * (bx + by));
            if (dst < nxt) begin
               ax = ax2; ay = ay2;
            end else begin
               cur = nxt; x += ax2; y += ay2; ax -= ax2; ay -= ay2;
            end
            continue;
         end
         if (mnr2[0] && mnr > 2) begin
            bx2 += dbx; by2 += dby;
         end
         nxt = cur + mag((bx2 + by2) * (ax2 + ay2));
         if (dst < nxt) begin
            t0 = ax2; t1 = ay2;
            ax = bx2; ay = by2; bx = t0; by = t1;
            continue;
         end
         cur = nxt;
         nxt = cur + mag((ax + ay) * ((bx - bx2) + (by - by2)));
         if (dst < nxt) begin
            x += bx2; y += by2; bx -= bx2; by -= by2;
            continue;
         end
         cur = nxt;
         x += (ax - dax) + (bx2 - dbx);
         y += (ay - day) + (by2 - dby);
         t0 = -bx2; t1 = -by2; t2 = -(ax - ax2); t3 = -(ay - ay2);
         ax = t0; ay = t1; bx = t2; by = t3;
      end
      c.x = x[CRD_W-1:0];
      c.y = y[CRD_W-1:0];
      return c;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic add_idx(logic [IDX_W-1:0] v);
      pending_idx = {pending_idx, v};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         expected_cells = {expected_cells, curve_cell(req_curve_index)};
         void'(pending_idx.pop_front());
         gap_left = pick_gap();
         if (pending_idx.size() > 0 && gap_left == 0) begin
            req_curve_index <= pending_idx[0];
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_idx.size() > 0) begin
            req_valid <= 1'b1;
            req_curve_index <= pending_idx[0];
         end
      end
   end

   always @(posedge clock) begin
      result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cells.size() == 0) begin
               $display("%0t: result with none expected: x=%0d y=%0d oor=%0b", $time,
                        rsp_x_coord, rsp_y_coord, rsp_out_of_range);
               failed = 1;
            end else begin
               e = expected_cells.pop_front();
               if (rsp_x_coord !== e.x || rsp_y_coord !== e.y
                   || rsp_out_of_range !== e.oor) begin
                  $display("%0t: expected x=%0d y=%0d oor=%0b, actual x=%0d y=%0d oor=%0b",
                           $time, e.x, e.y, e.oor, rsp_x_coord, rsp_y_coord,
                           rsp_out_of_range);
                  failed = 1;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_stall <= stall_left > 0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic drain();
      while (pending_idx.size() > 0 || req_valid || expected_cells.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_rect(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
      @(posedge clock);
      csr_write <= 1'b1; csr_index <= CSR_WIDTH; csr_data <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT; csr_data <= h;
      @(posedge clock);
      csr_write <= 1'b0;
      rect_width = w;
      rect_height = h;
   endtask

   task automatic run_random(int count);
      longint area;
      longint w, h;
      w = rect_width > 4096 ? 4096 : rect_width;
      h = rect_height > 4096 ? 4096 : rect_height;
      area = w * h;
      for (int i = 0; i < count; i++) begin
         if (area > 0 && $urandom_range(0, 9) != 0)
            add_idx(IDX_W'($urandom_range(0, int'(area - 1))));
         else if ($urandom_range(0, 1))
            add_idx(IDX_W'($urandom()));
         else
            add_idx(IDX_W'(area));
      end
      drain();
   endtask

   initial begin
      logic [REG_W-1:0] sizes[$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      // reset size is 1 x 1
      add_idx(24'd0);
      add_idx(24'd1);
      add_idx('1);
      drain();
      set_rect(13'd4096, 13'd4096);
      add_idx(24'd0);
      add_idx(24'd1);
      add_idx(24'hFFFFFF);
      add_idx(24'hFFFFFE);
      add_idx(24'h800000);
      add_idx(24'h555555);
      add_idx(24'hAAAAAA);
      drain();
      set_rect(13'd0, 13'd5);
      add_idx(24'd0);
      add_idx(24'd3);
      drain();
      set_rect(13'h1FFF, 13'd3);
      add_idx(24'd0);
      add_idx(24'd12287);
      add_idx(24'd12288);
      drain();
      set_rect(13'd7, 13'd1);
      for (int i = 0; i < 8; i++) add_idx(IDX_W'(i));
      drain();
      sizes = '{1, 2, 3, 5, 6, 8, 17, 64, 100, 255, 1000, 4095, 4096, 13'h1FFF, 0};
      for (int p = 0; p < 32; p++) begin
         logic [REG_W-1:0] w, h;
         w = p < 10 ? sizes[$urandom_range(0, sizes.size() - 1)]
                    : REG_W'($urandom_range(1, 40));
         h = $urandom_range(0, 1) ? sizes[$urandom_range(0, sizes.size() - 1)]
                                  : REG_W'($urandom_range(1, 300));
         if (p == 30) begin
            w = REG_W'($urandom_range(0, 13'h1FFF));
            h = REG_W'($urandom_range(0, 13'h1FFF));
         end
         set_rect(w, h);
         run_random(28);
      end
      if (!failed)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/gci_pkg.sv
rtl/core/gci_cell.sv
rtl/core/gilbert_curve_index_to_xy.sv
test/tb_gilbert_curve_index_to_xy.sv
